[sv/tpd_pkg.sv]
`default_nettype none
package tpd_pkg;

   localparam logic       OP_BYTE  = 1'b0;
   localparam logic       OP_TICK  = 1'b1;

   localparam logic [7:0] SYNC_BYTE    = 8'hff;
   localparam logic [7:0] RELEASE_BYTE = 8'hfe;

   localparam logic [1:0] KIND_MOTION = 2'd0;
   localparam logic [1:0] KIND_DOWN   = 2'd1;
   localparam logic [1:0] KIND_UP     = 2'd2;

   localparam logic [2:0] CSR_CAL_X      = 3'd0;
   localparam logic [2:0] CSR_CAL_Y      = 3'd1;
   localparam logic [2:0] CSR_SMOOTHNESS = 3'd2;
   localparam logic [2:0] CSR_JITTER     = 3'd3;
   localparam logic [2:0] CSR_TAPPING    = 3'd4;
   localparam logic [2:0] CSR_NO_DRAG    = 3'd5;
   localparam logic [2:0] CSR_BUTTON     = 3'd6;

   localparam logic [2:0] SEL_B1      = 3'd0;
   localparam logic [2:0] SEL_B2      = 3'd1;
   localparam logic [2:0] SEL_B3      = 3'd2;
   localparam logic [2:0] SEL_B2_ONCE = 3'd3;
   localparam logic [2:0] SEL_B3_ONCE = 3'd4;

   localparam logic [10:0] TICK_MAX = 11'd2047;

   localparam int MUL_STEPS = 4;
   localparam int DIV_STEPS = 20;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       sat;
      logic       load;
      logic       div_en;
      logic       commit;
      logic       pop;
   } tpd_cmd_type;

   typedef struct packed {
      logic touch;
      logic ev_pending;
      logic last;
   } tpd_status_type;

   function automatic logic [1:0] eff_button(input logic once, input logic [2:0] sel);
      logic [1:0] btn;
      btn = 2'd1;
      if (!once) begin
         case (sel)
            SEL_B2, SEL_B2_ONCE: btn = 2'd2;
            SEL_B3, SEL_B3_ONCE: btn = 2'd3;
            default: btn = 2'd1;
         endcase
      end
      return btn;
   endfunction

endpackage
`default_nettype wire

[sv/tpd_ctrl.sv]
`default_nettype none
module tpd_ctrl
   import tpd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire tpd_status_type status,
   output tpd_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL    = 7'b0000010,
      ST_SAT    = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_OUT    = 7'b1000000
   } tpd_state_type;

   tpd_state_type state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.mul_step = cnt_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (status.touch) begin
                  state_in = ST_MUL;
               end else if (status.ev_pending) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MUL_STEPS - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.ev_pending ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.pop = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[sv/tpd_datapath.sv]
`default_nettype none
module tpd_datapath
   import tpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        op,
   input  wire logic [7:0]  rx_byte,
   input  wire tpd_cmd_type cmd,
   output tpd_status_type   status,
   output logic [1:0]       ev_kind,
   output logic [1:0]       ev_button,
   output logic [15:0]      ev_x,
   output logic [15:0]      ev_y
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_B0   = 3'd1;
   localparam logic [2:0] PH_B1   = 3'd2;
   localparam logic [2:0] PH_B2   = 3'd3;
   localparam logic [2:0] PH_B3   = 3'd4;

   logic [63:0] cal_x_ff, cal_y_ff;
   logic [3:0]  smooth_ff;
   logic [9:0]  jitter_ff, tapping_ff;
   logic        no_drag_ff;
   logic [2:0]  sel_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  fb_ff [4];
   logic [15:0] avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic        was_rel_ff, was_rel_in, pen_ff, pen_in, pend_ff, pend_in;
   logic        once_ff, once_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic [10:0] tsr_ff, tsr_in;
   logic [3:0]  mask_ff, mask_in;
   logic [1:0]  btn_ff, btn_in;

   logic signed [39:0] acc_x_ff, acc_y_ff;
   logic [15:0] cx_ff, cy_ff;
   logic [19:0] qx_ff, qy_ff;
   logic [3:0]  rx_ff, ry_ff;
   logic [4:0]  d_ff;

   logic [15:0] xraw, yraw;
   logic [63:0] word;
   logic [19:0] gain;
   logic [15:0] raw;
   logic [23:0] off;
   logic signed [36:0] prod;
   logic signed [39:0] base, sum;
   logic [9:0]  cnt_dec;
   logic        fire, touch_byte;
   logic [15:0] nx, ny;

   assign xraw = {fb_ff[1], fb_ff[0]};
   assign yraw = {fb_ff[3], fb_ff[2]};
   assign word = cmd.mul_step[1] ? cal_y_ff : cal_x_ff;
   assign gain = cmd.mul_step[0] ? word[39:20] : word[19:0];
   assign raw  = cmd.mul_step[0] ? yraw : xraw;
   assign off  = word[63:40];
   assign prod = $signed(gain) * $signed({1'b0, raw});
   always_comb begin
      if (cmd.mul_step[0]) begin
         base = cmd.mul_step[1] ? acc_y_ff : acc_x_ff;
      end else begin
         base = $signed({{4{off[23]}}, off, 12'd0});
      end
      sum = base + 40'(prod);
   end

   function automatic logic [15:0] saturate(input logic signed [39:0] a);
      logic [15:0] r;
      if (a[39]) begin
         r = 16'd0;
      end else if (|a[38:28]) begin
         r = 16'hffff;
      end else begin
         r = a[27:12];
      end
      return r;
   endfunction

   assign nx = qx_ff[15:0];
   assign ny = qy_ff[15:0];
   assign cnt_dec    = (cnt_ff != 10'd0) ? cnt_ff - 10'd1 : 10'd0;
   assign touch_byte = (op == OP_BYTE) && (phase_ff == PH_B3);

   always_comb begin
      phase_in   = phase_ff;
      avg_x_in   = avg_x_ff;
      avg_y_in   = avg_y_ff;
      was_rel_in = was_rel_ff;
      pen_in     = pen_ff;
      pend_in    = pend_ff;
      once_in    = once_ff;
      cnt_in     = cnt_ff;
      tsr_in     = tsr_ff;
      mask_in    = mask_ff;
      btn_in     = btn_ff;
      fire       = 1'b0;
      if (cmd.accept) begin
         mask_in = '0;
         if (op == OP_TICK) begin
            if (tsr_ff != TICK_MAX) begin
               tsr_in = tsr_ff + 11'd1;
            end
            if (pend_ff) begin
               cnt_in = cnt_dec;
               fire   = (cnt_dec == 10'd0);
            end
         end else begin
            case (phase_ff)
               PH_B0: phase_in = PH_B1;
               PH_B1: begin
                  if (fb_ff[0] == RELEASE_BYTE && rx_byte == RELEASE_BYTE) begin
                     phase_in = PH_HUNT;
                     tsr_in   = '0;
                     if (jitter_ff != 10'd0) begin
                        pend_in = 1'b1;
                        cnt_in  = jitter_ff;
                     end else begin
                        fire = 1'b1;
                     end
                  end else begin
                     phase_in = PH_B2;
                  end
               end
               PH_B2: phase_in = PH_B3;
               PH_B3: phase_in = PH_HUNT;
               default: phase_in = (rx_byte == SYNC_BYTE) ? PH_B0 : PH_HUNT;
            endcase
         end
         if (fire) begin
            mask_in    = 4'b1000;
            btn_in     = eff_button(once_ff, sel_ff);
            if (sel_ff == SEL_B2_ONCE || sel_ff == SEL_B3_ONCE) begin
               once_in = 1'b1;
            end
            pen_in     = 1'b0;
            pend_in    = 1'b0;
            cnt_in     = '0;
            was_rel_in = 1'b1;
         end
      end
      if (cmd.commit) begin
         mask_in    = '0;
         btn_in     = eff_button(once_ff, sel_ff);
         was_rel_in = 1'b0;
         if (avg_x_ff != nx || avg_y_ff != ny) begin
            mask_in[0] = no_drag_ff;
            mask_in[1] = 1'b1;
         end
         if (!pen_ff) begin
            if (pend_ff) begin
               pend_in = 1'b0;
               cnt_in  = '0;
            end else if (tapping_ff == 10'd0 || tsr_ff < {1'b0, tapping_ff}) begin
               mask_in[2] = 1'b1;
            end
         end
         pen_in   = 1'b1;
         avg_x_in = nx;
         avg_y_in = ny;
      end
      if (cmd.pop) begin
         mask_in = mask_ff & (mask_ff - 4'd1);
      end
      if (csr_we && csr_addr == CSR_BUTTON) begin
         once_in = 1'b0;
      end
   end

   assign status.touch      = touch_byte;
   assign status.ev_pending = |mask_in;
   assign status.last       = $onehot(mask_ff);

   always_comb begin
      ev_kind   = KIND_UP;
      ev_button = btn_ff;
      if (!mask_ff[0] && mask_ff[1]) begin
         ev_kind   = KIND_MOTION;
         ev_button = 2'd0;
      end else if (!mask_ff[0] && !mask_ff[1] && mask_ff[2]) begin
         ev_kind   = KIND_DOWN;
      end
   end
   assign ev_x = avg_x_ff;
   assign ev_y = avg_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_ff   <= 64'd4096;
         cal_y_ff   <= 64'h0000_0001_0000_0000;
         smooth_ff  <= 4'd9;
         jitter_ff  <= 10'd50;
         tapping_ff <= 10'd0;
         no_drag_ff <= 1'b0;
         sel_ff     <= SEL_B1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CAL_X:      cal_x_ff   <= csr_wdata;
            CSR_CAL_Y:      cal_y_ff   <= csr_wdata;
            CSR_SMOOTHNESS: smooth_ff  <= csr_wdata[3:0];
            CSR_JITTER:     jitter_ff  <= csr_wdata[9:0];
            CSR_TAPPING:    tapping_ff <= csr_wdata[9:0];
            CSR_NO_DRAG:    no_drag_ff <= csr_wdata[0];
            CSR_BUTTON:     sel_ff     <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         avg_x_ff   <= 16'hffff;
         avg_y_ff   <= 16'hffff;
         was_rel_ff <= 1'b1;
         pen_ff     <= 1'b0;
         pend_ff    <= 1'b0;
         once_ff    <= 1'b0;
         cnt_ff     <= '0;
         tsr_ff     <= '0;
         mask_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         avg_x_ff   <= avg_x_in;
         avg_y_ff   <= avg_y_in;
         was_rel_ff <= was_rel_in;
         pen_ff     <= pen_in;
         pend_ff    <= pend_in;
         once_ff    <= once_in;
         cnt_ff     <= cnt_in;
         tsr_ff     <= tsr_in;
         mask_ff    <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      btn_ff <= btn_in;
      if (cmd.accept && op == OP_BYTE) begin
         case (phase_ff)
            PH_B0: fb_ff[0] <= rx_byte;
            PH_B1: fb_ff[1] <= rx_byte;
            PH_B2: fb_ff[2] <= rx_byte;
            PH_B3: fb_ff[3] <= rx_byte;
            default: ;
         endcase
      end
      if (cmd.mul_en) begin
         if (cmd.mul_step[1]) begin
            acc_y_ff <= sum;
         end else begin
            acc_x_ff <= sum;
         end
      end
      if (cmd.sat) begin
         cx_ff <= saturate(acc_x_ff);
         cy_ff <= saturate(acc_y_ff);
      end
      if (cmd.load) begin
         if (was_rel_ff) begin
            qx_ff <= {4'd0, cx_ff};
            qy_ff <= {4'd0, cy_ff};
            d_ff  <= 5'd1;
         end else begin
            qx_ff <= ({4'd0, avg_x_ff} * {16'd0, smooth_ff}) + {4'd0, cx_ff};
            qy_ff <= ({4'd0, avg_y_ff} * {16'd0, smooth_ff}) + {4'd0, cy_ff};
            d_ff  <= {1'b0, smooth_ff} + 5'd1;
         end
         rx_ff <= '0;
         ry_ff <= '0;
      end
      if (cmd.div_en) begin
         if ({rx_ff, qx_ff[19]} >= d_ff) begin
            rx_ff <= 4'({rx_ff, qx_ff[19]} - d_ff);
            qx_ff <= {qx_ff[18:0], 1'b1};
         end else begin
            rx_ff <= {rx_ff[2:0], qx_ff[19]};
            qx_ff <= {qx_ff[18:0], 1'b0};
         end
         if ({ry_ff, qy_ff[19]} >= d_ff) begin
            ry_ff <= 4'({ry_ff, qy_ff[19]} - d_ff);
            qy_ff <= {qy_ff[18:0], 1'b1};
         end else begin
            ry_ff <= {ry_ff[2:0], qy_ff[19]};
            qy_ff <= {qy_ff[18:0], 1'b0};
         end
      end
   end

endmodule
`default_nettype wire

[sv/touch_packet_decoder_core.sv]
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata rx_byte, tuser operation
// rsp       out        rsp_tvalid/rsp_tready  tdata button/x/y, tuser kind, tlast
// csr       in         csr_we                 csr_addr, csr_wdata
//
// A tick or a byte that does not end a touch packet is taken directly from idle, and goes to
// the event output only if an event is pending. The last byte of a touch packet passes through
// four multiply-accumulate steps on one shared multiplier, saturation, load, a 20-step radix-2
// divider for the averaging, and commit before any events appear.
// Each event is held until rsp_tready; no request is taken meanwhile.
// Reset is synchronous and active high and restores the register defaults.
module touch_packet_decoder_core
   import tpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [1:0] button_number, [17:2] x_pos, [33:18] y_pos
   output logic [1:0]       rsp_tuser,   // [1:0] event_kind
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   tpd_cmd_type    cmd;
   tpd_status_type status;
   logic [1:0]     ev_button;
   logic [15:0]    ev_x, ev_y;

   tpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tpd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .op        (req_tuser),
      .rx_byte   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .ev_kind   (rsp_tuser),
      .ev_button (ev_button),
      .ev_x      (ev_x),
      .ev_y      (ev_y)
   );

   assign rsp_tdata = {6'd0, ev_y, ev_x, ev_button};
   assign rsp_tlast = status.last;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request accepted while an event is waiting");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("events continue after the final one");

   a_valid_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tuser) <= 1)
      else $error("event kind out of range");

endmodule
`default_nettype wire
